[sv/exception_table_range_lookup_defines.svh]
// Assertion macros shared by the exception table lookup modules.
// Depends on nothing; users must have i_clk and i_rst_n in scope.
// Each check is compiled only outside synthesis.
`ifndef EXCEPTION_TABLE_RANGE_LOOKUP_DEFINES_SVH
`define EXCEPTION_TABLE_RANGE_LOOKUP_DEFINES_SVH

`ifndef SYNTHESIS
`define ETRL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ETRL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ETRL_ASSERT_SAME(lbl, ante, cons, msg)
`define ETRL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[sv/etrl_pkg.sv]
// Shared types and constants of the exception table range lookup.
// Depends on nothing; imported by every module of the block.

package etrl_pkg;

    localparam int ETRL_CODE_UNIT_BYTES = 2;

    localparam int VALUE_W   = 31;
    localparam int PAYLOAD_W = 6;
    localparam logic [VALUE_W-1:0] ACCUM_LIMIT = 31'h01FF_FFFF;

    typedef enum logic [1:0] {
        ST_HIT       = 2'd0,
        ST_MISS      = 2'd1,
        ST_MALFORMED = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0]         table_byte;
        logic               first_byte;
        logic               last_byte;
        logic signed [31:0] query_offset;
    } t_item;

    typedef struct packed {
        t_status      status;
        logic [30:0]  handler_offset;
        logic [29:0]  handler_depth;
        logic         push_lasti;
    } t_result;

endpackage

[sv/etrl_parser.sv]
// Varint decoder and record evaluator for the exception table lookup.
// Depends on etrl_pkg and the assertion macro header.

`include "exception_table_range_lookup_defines.svh"

module etrl_parser
    import etrl_pkg::*;
#(
    parameter int CODE_UNIT_BYTES = ETRL_CODE_UNIT_BYTES
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_item   i_item,
    output logic    o_push,
    output t_result o_result
);

    localparam int MUL_W = VALUE_W + $clog2(CODE_UNIT_BYTES + 1);

    localparam logic [1:0] FLD_START  = 2'd0;
    localparam logic [1:0] FLD_SIZE   = 2'd1;
    localparam logic [1:0] FLD_TARGET = 2'd2;
    localparam logic [1:0] FLD_PACKED = 2'd3;

    logic [VALUE_W-1:0] r_query, n_query;
    logic [1:0]         r_field, n_field;
    logic [VALUE_W-1:0] r_accum, n_accum;
    logic               r_in_var, n_in_var;
    logic               r_done, n_done;
    logic [VALUE_W-1:0] r_start_b, n_start_b;
    logic [VALUE_W-1:0] r_size_b, n_size_b;
    logic [VALUE_W-1:0] r_targ_b, n_targ_b;
    logic               r_start_ovf, n_start_ovf;
    logic               r_size_ovf, n_size_ovf;
    logic               r_targ_ovf, n_targ_ovf;

    logic [1:0]         c_field;
    logic               c_in_var;
    logic               c_done;
    logic [VALUE_W-1:0] c_acc;
    logic [MUL_W-1:0]   c_prod;
    logic               c_prod_ovf;
    logic [VALUE_W:0]   c_end;
    logic               c_hit;

    // Scaled copy of the varint just finished; stored with its overflow flag.
    assign c_prod     = MUL_W'(c_acc) * MUL_W'(CODE_UNIT_BYTES);
    assign c_prod_ovf = |c_prod[MUL_W-1:VALUE_W];
    assign c_end      = {1'b0, r_start_b} + {1'b0, r_size_b};
    assign c_hit      = (r_start_b <= r_query) && ({1'b0, r_query} < c_end);

    always_comb begin
        n_query     = r_query;
        n_field     = r_field;
        n_accum     = r_accum;
        n_in_var    = r_in_var;
        n_done      = r_done;
        n_start_b   = r_start_b;
        n_size_b    = r_size_b;
        n_targ_b    = r_targ_b;
        n_start_ovf = r_start_ovf;
        n_size_ovf  = r_size_ovf;
        n_targ_ovf  = r_targ_ovf;
        o_push      = 1'b0;
        o_result    = '{status: ST_MISS, handler_offset: '0, handler_depth: '0,
                        push_lasti: 1'b0};

        c_field  = i_item.first_byte ? FLD_START : r_field;
        c_in_var = i_item.first_byte ? 1'b0 : r_in_var;
        c_done   = i_item.first_byte ? 1'b0 : r_done;
        c_acc    = c_in_var ? {r_accum[VALUE_W-PAYLOAD_W-1:0], i_item.table_byte[5:0]}
                            : VALUE_W'(i_item.table_byte[5:0]);

        if (i_accept) begin
            n_field  = c_field;
            n_in_var = c_in_var;
            n_done   = c_done;
            if (i_item.first_byte) begin
                n_query = i_item.query_offset[30:0];
            end
            if (i_item.first_byte && i_item.query_offset[31]) begin
                o_push = 1'b1;
                n_done = 1'b1;
            end else if (!c_done) begin
                if (c_in_var && (r_accum > ACCUM_LIMIT)) begin
                    o_push          = 1'b1;
                    o_result.status = ST_MALFORMED;
                    n_done          = 1'b1;
                end else if (i_item.table_byte[6]) begin
                    n_accum  = c_acc;
                    n_in_var = 1'b1;
                    if (i_item.last_byte) begin
                        o_push          = 1'b1;
                        o_result.status = ST_MALFORMED;
                        n_done          = 1'b1;
                    end
                end else begin
                    n_accum  = c_acc;
                    n_in_var = 1'b0;
                    n_field  = c_field + 2'd1;
                    case (c_field)
                        FLD_START: begin
                            n_start_b   = c_prod[VALUE_W-1:0];
                            n_start_ovf = c_prod_ovf;
                        end
                        FLD_SIZE: begin
                            n_size_b   = c_prod[VALUE_W-1:0];
                            n_size_ovf = c_prod_ovf;
                        end
                        FLD_TARGET: begin
                            n_targ_b   = c_prod[VALUE_W-1:0];
                            n_targ_ovf = c_prod_ovf;
                        end
                        default: begin
                            n_field = FLD_START;
                        end
                    endcase
                    if (c_field != FLD_PACKED) begin
                        if (i_item.last_byte) begin
                            o_push          = 1'b1;
                            o_result.status = ST_MALFORMED;
                            n_done          = 1'b1;
                        end
                    end else if (r_start_ovf || r_size_ovf || r_targ_ovf
                                 || c_end[VALUE_W]) begin
                        o_push          = 1'b1;
                        o_result.status = ST_MALFORMED;
                        n_done          = 1'b1;
                    end else if (c_hit) begin
                        o_push                  = 1'b1;
                        o_result.status         = ST_HIT;
                        o_result.handler_offset = r_targ_b;
                        o_result.handler_depth  = c_acc[VALUE_W-1:1];
                        o_result.push_lasti     = c_acc[0];
                        n_done                  = 1'b1;
                    end else if (i_item.last_byte) begin
                        o_push = 1'b1;
                        n_done = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field  <= FLD_START;
            r_in_var <= 1'b0;
            r_done   <= 1'b1;
            r_query  <= '0;
        end else begin
            r_field  <= n_field;
            r_in_var <= n_in_var;
            r_done   <= n_done;
            r_query  <= n_query;
        end
    end

    always_ff @(posedge i_clk) begin
        r_accum     <= n_accum;
        r_start_b   <= n_start_b;
        r_size_b    <= n_size_b;
        r_targ_b    <= n_targ_b;
        r_start_ovf <= n_start_ovf;
        r_size_ovf  <= n_size_ovf;
        r_targ_ovf  <= n_targ_ovf;
    end

    `ETRL_ASSERT_NEXT(a_push_ends_lookup, o_push, r_done, "lookup still active after a result")
    `ETRL_ASSERT_SAME(a_push_needs_accept, o_push, i_accept, "result without an accepted item")
    `ETRL_ASSERT_SAME(a_miss_fields_zero, o_push && (o_result.status != ST_HIT),
        (o_result.handler_offset == '0) && (o_result.handler_depth == '0) && !o_result.push_lasti,
        "non-hit result carries handler fields")

endmodule

[sv/etrl_out_buf.sv]
// Output register with one skid entry for the lookup results.
// Depends on etrl_pkg and the assertion macro header.

`include "exception_table_range_lookup_defines.svh"

module etrl_out_buf
    import etrl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_space,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_data
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    c_take;

    assign c_take  = r_out_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            // The producer is held off while the skid entry is full.
            if (c_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (!r_out_valid || c_take) begin
            n_out_valid = i_push;
            n_out       = i_data;
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    `ETRL_ASSERT_SAME(a_skid_behind_out, r_skid_valid, r_out_valid, "skid full with output empty")
    `ETRL_ASSERT_SAME(a_no_push_when_full, i_push, !r_skid_valid, "push into a full buffer")
    `ETRL_ASSERT_NEXT(a_skid_drains, r_skid_valid && c_take, r_out_valid && !r_skid_valid,
        "skid entry not moved forward")

endmodule

[sv/exception_table_range_lookup.sv]
// A result item is registered in the output buffer before it appears on o_result_valid.
// Throughput: one table byte per cycle; input is held off only while both output slots are full.
// Each byte passes one varint shift-and-merge step and, on a record's last varint, one add and
// range compare. Reset (synchronous, active low) empties the output and leaves the block idle,
// ignoring bytes until a byte marked first starts a lookup.
// Top level of the exception table range lookup; depends on etrl_pkg, etrl_parser, etrl_out_buf.

module exception_table_range_lookup
    import etrl_pkg::*;
#(
    parameter int CODE_UNIT_BYTES = ETRL_CODE_UNIT_BYTES
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_valid,
    output logic    o_item_ready,
    input  t_item   i_item,
    output logic    o_result_valid,
    input  logic    i_result_ready,
    output t_result o_result
);

    // The parser owns the decode state: latched query, field counter, varint accumulator and the
    // three scaled record fields. Every accepted item advances it by exactly one byte.
    logic    accept;
    logic    push;
    logic    space;
    t_result result;

    // The output side is decoupled by a two-entry buffer, so ready does not depend on the
    // downstream ready in the same cycle. A new item is taken whenever the skid entry is free.
    assign o_item_ready = space;
    assign accept       = i_item_valid && space;

    etrl_parser #(
        .CODE_UNIT_BYTES(CODE_UNIT_BYTES)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_push   (push),
        .o_result (result)
    );

    // At most one result item per accepted byte: hit, miss or malformed, then the lookup idles.
    etrl_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .o_space (space),
        .i_ready (i_result_ready),
        .o_valid (o_result_valid),
        .o_data  (o_result)
    );

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for exception_table_range_lookup: streams encoded exception tables
// as byte items and checks every lookup result against a predictor kept in this file.
// Depends on etrl_pkg and the exception_table_range_lookup RTL only.

module tb;
    import etrl_pkg::*;

    // Code unit size used both for the block and for the byte scaling in the predictor.
    localparam int UNIT = ETRL_CODE_UNIT_BYTES;
    localparam logic [63:0] MAX31 = 64'h7FFF_FFFF;
    localparam int RANDOM_ITEMS = 1500;

    // The four varints of one exception table record, in stream order.
    typedef enum logic [1:0] {
        FLD_START  = 2'd0,
        FLD_SIZE   = 2'd1,
        FLD_TARGET = 2'd2,
        FLD_PACKED = 2'd3
    } t_field;

    // One row of the directed table. When typed is set, the expectation in the row is
    // used as written; otherwise the predictor decides what the item must produce.
    typedef struct packed {
        t_item   item;
        bit      typed;
        bit      has_res;
        t_result res;
    } t_dir_row;

    localparam t_result NO_RES = '0;

    localparam t_dir_row DIRECTED [26] = '{
        // A negative query (the most negative one) misses on the first byte.
        '{'{8'hFF, 1'b1, 1'b0, 32'h8000_0000}, 1'b1, 1'b1, '{ST_MISS, 31'd0, 30'd0, 1'b0}},
        // The rest of that table is ignored, even a byte marked last.
        '{'{8'h41, 1'b0, 1'b1, 32'h7FFF_FFFF}, 1'b1, 1'b0, NO_RES},
        // A lookup restarted in the middle of a table, then a record that does not
        // cover the query at the table end: start 4 bytes, end 6, query 10.
        '{'{8'h00, 1'b1, 1'b0, 32'd10}, 1'b0, 1'b0, NO_RES},
        '{'{8'h02, 1'b1, 1'b0, 32'd10}, 1'b0, 1'b0, NO_RES},
        '{'{8'h01, 1'b0, 1'b0, 32'd0}, 1'b0, 1'b0, NO_RES},
        '{'{8'h03, 1'b0, 1'b0, 32'd0}, 1'b0, 1'b0, NO_RES},
        '{'{8'h04, 1'b0, 1'b1, 32'd0}, 1'b1, 1'b1, '{ST_MISS, 31'd0, 30'd0, 1'b0}},
        // A covering record, bit 7 set on its first byte: handler 3 units, packed word 5.
        '{'{8'h82, 1'b1, 1'b0, 32'd4}, 1'b0, 1'b0, NO_RES},
        '{'{8'h01, 1'b0, 1'b0, 32'd0}, 1'b0, 1'b0, NO_RES},
        '{'{8'h03, 1'b0, 1'b0, 32'd0}, 1'b0, 1'b0, NO_RES},
        '{'{8'h05, 1'b0, 1'b1, 32'd0}, 1'b1, 1'b1, '{ST_HIT, 31'd6, 30'd2, 1'b1}},
        // The last byte asks for another byte.
        '{'{8'h7F, 1'b1, 1'b1, 32'd0}, 1'b1, 1'b1, '{ST_MALFORMED, 31'd0, 30'd0, 1'b0}},
        // A varint that keeps going after 30 bits of payload.
        '{'{8'hFF, 1'b1, 1'b0, 32'd5}, 1'b0, 1'b0, NO_RES},
        '{'{8'h7F, 1'b0, 1'b0, 32'd0}, 1'b0, 1'b0, NO_RES},
        '{'{8'h7F, 1'b0, 1'b0, 32'd0}, 1'b0, 1'b0, NO_RES},
        '{'{8'h7F, 1'b0, 1'b0, 32'd0}, 1'b0, 1'b0, NO_RES},
        '{'{8'h7F, 1'b0, 1'b0, 32'd0}, 1'b0, 1'b0, NO_RES},
        '{'{8'h40, 1'b0, 1'b0, 32'd0}, 1'b1, 1'b1, '{ST_MALFORMED, 31'd0, 30'd0, 1'b0}},
        // Largest query; start 0x3FFFFFFF units plus one unit runs past 31 bits in bytes.
        '{'{8'h7F, 1'b1, 1'b0, 32'h7FFF_FFFF}, 1'b0, 1'b0, NO_RES},
        '{'{8'h7F, 1'b0, 1'b0, 32'd0}, 1'b0, 1'b0, NO_RES},
        '{'{8'h7F, 1'b0, 1'b0, 32'd0}, 1'b0, 1'b0, NO_RES},
        '{'{8'h7F, 1'b0, 1'b0, 32'd0}, 1'b0, 1'b0, NO_RES},
        '{'{8'h3F, 1'b0, 1'b0, 32'd0}, 1'b0, 1'b0, NO_RES},
        '{'{8'h01, 1'b0, 1'b0, 32'd0}, 1'b0, 1'b0, NO_RES},
        '{'{8'h00, 1'b0, 1'b0, 32'd0}, 1'b0, 1'b0, NO_RES},
        '{'{8'h00, 1'b0, 1'b1, 32'd0}, 1'b1, 1'b1, '{ST_MALFORMED, 31'd0, 30'd0, 1'b0}}
    };

    // Every input of the block has a known value from time zero.
    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    t_item   item = '0;
    logic    result_ready = 1'b0;
    logic    item_ready;
    logic    result_valid;
    t_result result;

    // Idle rates in percent of cycles for the sending and the receiving side.
    int unsigned send_idle_pct = 36;
    int unsigned recv_idle_pct = 80;

    t_result     pending_results[$];
    int unsigned error_count = 0;

    // Predictor state: a copy of the lookup's own registers.
    logic signed [31:0] query_lat;
    t_field             field_idx;
    logic [30:0]        varint_val;
    logic               mid_varint;
    logic [30:0]        rec_start;
    logic [30:0]        rec_len;
    logic [30:0]        rec_handler;
    logic               lookup_idle;

    exception_table_range_lookup #(
        .CODE_UNIT_BYTES(UNIT)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_item_valid   (item_valid),
        .o_item_ready   (item_ready),
        .i_item         (item),
        .o_result_valid (result_valid),
        .i_result_ready (result_ready),
        .o_result       (result)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Ends the lookup with a result that carries only a status.
    function automatic t_result close_lookup(input t_status st);
        t_result r;
        r = '0;
        r.status = st;
        lookup_idle = 1'b1;
        return r;
    endfunction

    // Advances the predicted lookup by one table byte. Returns 1 when the byte
    // produces a result, which is then placed in r.
    function automatic bit lookup_step(input t_item it, output t_result r);
        logic [63:0] start_b;
        logic [63:0] len_b;
        logic [63:0] tgt_b;
        logic [63:0] qry_b;
        r = '0;
        if (it.first_byte) begin
            field_idx   = FLD_START;
            varint_val  = '0;
            mid_varint  = 1'b0;
            rec_start   = '0;
            rec_len     = '0;
            rec_handler = '0;
            lookup_idle = 1'b0;
            query_lat   = it.query_offset;
            if (it.query_offset[31]) begin
                r = close_lookup(ST_MISS);
                return 1'b1;
            end
        end
        if (lookup_idle)
            return 1'b0;

        // Merge the 6-bit payload; a continuation onto a too-large value overflows.
        if (mid_varint) begin
            if (varint_val > ACCUM_LIMIT) begin
                r = close_lookup(ST_MALFORMED);
                return 1'b1;
            end
            varint_val = {varint_val[24:0], it.table_byte[5:0]};
        end else begin
            varint_val = {25'd0, it.table_byte[5:0]};
        end

        mid_varint = it.table_byte[6];
        if (mid_varint) begin
            if (it.last_byte)
                r = close_lookup(ST_MALFORMED);
            return it.last_byte;
        end

        if (field_idx != FLD_PACKED) begin
            case (field_idx)
                FLD_START: rec_start   = varint_val;
                FLD_SIZE:  rec_len     = varint_val;
                default:   rec_handler = varint_val;
            endcase
            field_idx = t_field'(field_idx + 2'd1);
            // A table may only end after the packed word of a record.
            if (it.last_byte)
                r = close_lookup(ST_MALFORMED);
            return it.last_byte;
        end

        // The record is complete: scale to bytes, then test whether it covers the query.
        field_idx = FLD_START;
        start_b = 64'(rec_start) * UNIT;
        len_b   = 64'(rec_len) * UNIT;
        tgt_b   = 64'(rec_handler) * UNIT;
        qry_b   = {32'd0, query_lat};
        if (start_b > MAX31 || len_b > MAX31 || tgt_b > MAX31 || start_b + len_b > MAX31) begin
            r = close_lookup(ST_MALFORMED);
            return 1'b1;
        end
        if (start_b <= qry_b && qry_b < start_b + len_b) begin
            r = close_lookup(ST_HIT);
            r.handler_offset = tgt_b[30:0];
            r.handler_depth  = varint_val[30:1];
            r.push_lasti     = varint_val[0];
            return 1'b1;
        end
        if (it.last_byte)
            r = close_lookup(ST_MISS);
        return it.last_byte;
    endfunction

    // Offers one item, with random idle cycles before it, and records what it must
    // produce once the block has taken it.
    task automatic push_item(input t_item it, input bit typed, input bit typed_has,
                             input t_result typed_res);
        t_result predicted;
        bit      has;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        has = lookup_step(it, predicted);
        if (typed) begin
            has       = typed_has;
            predicted = typed_res;
        end
        if (has)
            pending_results.push_back(predicted);
    endtask

    // Sends a table as a run of items; query_offset is random on all but the first.
    task automatic send_table(input logic [7:0] tbl[$], input logic [31:0] qry,
                              input bit mark_last);
        t_item it;
        foreach (tbl[i]) begin
            it.table_byte   = tbl[i];
            it.first_byte   = (i == 0);
            it.last_byte    = mark_last && (i == tbl.size() - 1);
            it.query_offset = (i == 0) ? qry : $urandom;
            push_item(it, 1'b0, 1'b0, NO_RES);
        end
    endtask

    // Appends a big-endian varint, sometimes with a redundant leading zero group.
    function automatic void put_varint(ref logic [7:0] tbl[$], input logic [30:0] v);
        int n;
        n = 1;
        while (n < 6 && (v >> (6 * n)) != 0)
            n++;
        if (n < 6 && $urandom_range(0, 7) == 0)
            n++;
        for (int i = n - 1; i >= 0; i--)
            tbl.push_back({1'($urandom_range(0, 1)), i != 0, 6'(v >> (6 * i))});
    endfunction

    // Mostly small code unit values, some medium, a few that overflow once scaled.
    function automatic logic [30:0] rand_units();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 31'($urandom_range(0, 40));
            6, 7:             return 31'($urandom_range(0, 'hFFFF));
            8:                return 31'($urandom);
            default:          return 31'($urandom_range('h3FFF_FFF0, 'h4000_000F));
        endcase
    endfunction

    // The receiving side stalls at the rate of the current phase.
    always @(posedge clk)
        result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Result items are compared field by field with the oldest expectation. The values
    // read here are the ones from before this edge, so the handshake is sampled cleanly.
    always @(posedge clk) begin
        if (rst_n && result_valid && result_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with none expected: status %0d", result.status);
                error_count++;
            end else begin
                if (result.status !== pending_results[0].status) begin
                    $error("status: expected %0d, got %0d",
                           pending_results[0].status, result.status);
                    error_count++;
                end
                if (result.handler_offset !== pending_results[0].handler_offset) begin
                    $error("handler_offset: expected %0d, got %0d",
                           pending_results[0].handler_offset, result.handler_offset);
                    error_count++;
                end
                if (result.handler_depth !== pending_results[0].handler_depth) begin
                    $error("handler_depth: expected %0d, got %0d",
                           pending_results[0].handler_depth, result.handler_depth);
                    error_count++;
                end
                if (result.push_lasti !== pending_results[0].push_lasti) begin
                    $error("push_lasti: expected %0d, got %0d",
                           pending_results[0].push_lasti, result.push_lasti);
                    error_count++;
                end
                void'(pending_results.pop_front());
            end
        end
    end

    initial begin
        logic [7:0]  tbl[$];
        longint      rec_lo[$];
        longint      rec_span[$];
        logic [31:0] qry;
        logic [63:0] qv;
        int unsigned items_sent;
        int unsigned rec_n;
        int unsigned kind;
        int unsigned pick;
        int unsigned k;
        bit          mark_last;
        t_item       idle_it;

        // The predictor starts out as the block does after reset.
        query_lat   = '0;
        field_idx   = FLD_START;
        varint_val  = '0;
        mid_varint  = 1'b0;
        rec_start   = '0;
        rec_len     = '0;
        rec_handler = '0;
        lookup_idle = 1'b1;
        items_sent  = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
            push_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].has_res,
                      DIRECTED[i].res);

        while (items_sent < RANDOM_ITEMS) begin
            // Three idling phases: slow receiver, then slow sender, then no gaps at all.
            if (items_sent >= 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (items_sent >= RANDOM_ITEMS / 3) begin
                send_idle_pct = 80;
                recv_idle_pct = 36;
            end

            // Build a well-formed table of one to four records.
            tbl.delete();
            rec_lo.delete();
            rec_span.delete();
            rec_n = $urandom_range(1, 4);
            for (int r = 0; r < rec_n; r++) begin
                logic [30:0] s;
                logic [30:0] l;
                s = rand_units();
                l = rand_units();
                rec_lo.push_back(longint'(s) * UNIT);
                rec_span.push_back(longint'(l) * UNIT);
                put_varint(tbl, s);
                put_varint(tbl, l);
                put_varint(tbl, rand_units());
                put_varint(tbl, ($urandom_range(0, 1) == 1) ? 31'($urandom_range(0, 15))
                                                             : 31'($urandom));
            end

            // Aim the query at or just past a record half of the time.
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                k  = $urandom_range(0, rec_n - 1);
                qv = 64'(rec_lo[k] + (longint'($urandom) % (rec_span[k] + 2)));
                qry = {1'b0, qv[30:0]};
            end else if (pick < 80) begin
                qry = $urandom_range(0, 200);
            end else if (pick < 95) begin
                qry = {1'b0, 31'($urandom)};
            end else begin
                qry = $urandom | 32'h8000_0000;
            end

            // Damage a minority of the tables.
            mark_last = 1'b1;
            kind = $urandom_range(0, 99);
            if (kind < 18 && tbl.size() > 1) begin
                // Truncated; without a last marker the next table restarts the lookup.
                k = $urandom_range(1, tbl.size() - 1);
                while (tbl.size() > k)
                    void'(tbl.pop_back());
                mark_last = (kind < 12);
            end else if (kind < 24) begin
                tbl.delete();
                repeat ($urandom_range(1, 12))
                    tbl.push_back(8'($urandom));
            end else if (kind < 28) begin
                repeat ($urandom_range(6, 8))
                    tbl.push_front(8'($urandom) | 8'h40);
            end

            send_table(tbl, qry, mark_last);
            items_sent += tbl.size();

            // Now and then a few stray bytes with no lookup in progress.
            if ($urandom_range(0, 4) == 0 && mark_last) begin
                repeat ($urandom_range(1, 3)) begin
                    idle_it.table_byte   = 8'($urandom);
                    idle_it.first_byte   = 1'b0;
                    idle_it.last_byte    = 1'($urandom_range(0, 1));
                    idle_it.query_offset = $urandom;
                    push_item(idle_it, 1'b0, 1'b0, NO_RES);
                end
            end
        end

        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Ends the run as a failure if the bench has not finished by the time limit.
    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

[exception_table_range_lookup.f]
+incdir+sv
sv/etrl_pkg.sv
sv/etrl_parser.sv
sv/etrl_out_buf.sv
sv/exception_table_range_lookup.sv
verif/tb.sv
